// ===== src/cpu8alu_pkg.sv =====
// ----------------------------------------------------------------------------
// cpu8alu_pkg - shared types for the 8-bit ALU and flags unit
// Operation and register-select codes, architectural state and result types.
// ----------------------------------------------------------------------------
package cpu8alu_pkg;

	typedef enum logic [3:0] {
		OP_LOAD  = 4'd0,
		OP_STORE = 4'd1,
		OP_ADC   = 4'd2,
		OP_SBC   = 4'd3,
		OP_AND   = 4'd4,
		OP_ORA   = 4'd5,
		OP_EOR   = 4'd6,
		OP_ASL_A = 4'd7,
		OP_ASL_M = 4'd8,
		OP_LSR_A = 4'd9,
		OP_LSR_M = 4'd10,
		OP_INC_M = 4'd11,
		OP_DEC_M = 4'd12,
		OP_DEC_R = 4'd13,
		OP_CMP   = 4'd14,
		OP_BIT   = 4'd15
	} op_t;

	typedef enum logic [1:0] {
		SEL_A    = 2'd0,
		SEL_X    = 2'd1,
		SEL_Y    = 2'd2,
		SEL_NONE = 2'd3
	} sel_t;

	typedef struct packed {
		logic c;
		logic z;
		logic v;
		logic n;
	} flags_t;

	typedef struct packed {
		logic [7:0] acc;
		logic [7:0] idx_x;
		logic [7:0] idx_y;
		flags_t     flags;
	} arch_t;

	typedef struct packed {
		logic [7:0] value;
		logic       wr;
	} wb_t;

endpackage

// ===== src/cpu8alu_cmd_if.sv =====
// ----------------------------------------------------------------------------
// cpu8alu_cmd_if - operation channel
// Valid/ready channel carrying one operation, its operand and address.
// ----------------------------------------------------------------------------
interface cpu8alu_cmd_if;
	logic        valid;
	logic        ready;
	logic [3:0]  operation;
	logic [1:0]  reg_select;
	logic [7:0]  operand;
	logic [15:0] address;

	modport source (output valid, operation, reg_select, operand, address, input ready);
	modport sink (input valid, operation, reg_select, operand, address, output ready);
endinterface

// ===== src/cpu8alu_res_if.sv =====
// ----------------------------------------------------------------------------
// cpu8alu_res_if - result channel
// Valid/ready channel carrying write-back data, accumulator and flags.
// ----------------------------------------------------------------------------
interface cpu8alu_res_if;
	logic        valid;
	logic        ready;
	logic [7:0]  result_value;
	logic        mem_write;
	logic [15:0] write_address;
	logic [7:0]  accumulator_out;
	logic        carry;
	logic        zero;
	logic        overflow;
	logic        negative;

	modport source (output valid, result_value, mem_write, write_address, accumulator_out,
		carry, zero, overflow, negative, input ready);
	modport sink (input valid, result_value, mem_write, write_address, accumulator_out,
		carry, zero, overflow, negative, output ready);
endinterface

// ===== src/cpu8alu_exec.sv =====
// ----------------------------------------------------------------------------
// cpu8alu_exec - ALU datapath
// Computes next register/flag state and memory write-back for one operation.
// ----------------------------------------------------------------------------
module cpu8alu_exec
	import cpu8alu_pkg::*;
(
	input  arch_t      cur,
	input  op_t        op,
	input  sel_t       sel,
	input  logic [7:0] operand,
	output arch_t      nxt,
	output wb_t        wb
);

	logic [7:0] reg_val;
	logic [7:0] add_arg;
	logic [8:0] sum;
	logic [8:0] diff;
	logic [7:0] sh_l;
	logic [7:0] sh_r;
	logic [7:0] inc_v;
	logic [7:0] dec_v;
	logic [7:0] reg_dec;

	always_comb begin
		unique case (sel)
			SEL_A:   reg_val = cur.acc;
			SEL_X:   reg_val = cur.idx_x;
			SEL_Y:   reg_val = cur.idx_y;
			default: reg_val = 8'h00;
		endcase
	end

	// subtract is add of the inverted operand, carry as not-borrow
	assign add_arg = (op == OP_SBC) ? ~operand : operand;
	assign sum     = {1'b0, cur.acc} + {1'b0, add_arg} + {8'h00, cur.flags.c};
	assign diff    = {1'b0, reg_val} - {1'b0, operand};
	assign inc_v   = operand + 8'h01;
	assign dec_v   = operand - 8'h01;
	assign reg_dec = reg_val - 8'h01;

	// shift source: accumulator or memory byte
	always_comb begin
		logic [7:0] src;
		src  = (op == OP_ASL_A || op == OP_LSR_A) ? cur.acc : operand;
		sh_l = {src[6:0], 1'b0};
		sh_r = {1'b0, src[7:1]};
	end

	always_comb begin
		nxt      = cur;
		wb.value = 8'h00;
		wb.wr    = 1'b0;
		unique case (op)
			OP_LOAD: begin
				if (sel != SEL_NONE) begin
					if (sel == SEL_A) nxt.acc = operand;
					if (sel == SEL_X) nxt.idx_x = operand;
					if (sel == SEL_Y) nxt.idx_y = operand;
					nxt.flags.z = (operand == 8'h00);
					nxt.flags.n = operand[7];
				end
			end
			OP_STORE: begin
				if (sel != SEL_NONE) begin
					wb.value = reg_val;
					wb.wr    = 1'b1;
				end
			end
			OP_ADC, OP_SBC: begin
				nxt.acc     = sum[7:0];
				nxt.flags.c = sum[8];
				nxt.flags.v = ~(cur.acc[7] ^ add_arg[7]) & (cur.acc[7] ^ sum[7]);
				nxt.flags.z = (sum[7:0] == 8'h00);
				nxt.flags.n = sum[7];
			end
			OP_AND, OP_ORA, OP_EOR: begin
				if (op == OP_AND) nxt.acc = cur.acc & operand;
				else if (op == OP_ORA) nxt.acc = cur.acc | operand;
				else nxt.acc = cur.acc ^ operand;
				nxt.flags.z = (nxt.acc == 8'h00);
				nxt.flags.n = nxt.acc[7];
			end
			OP_ASL_A, OP_ASL_M: begin
				nxt.flags.c = (op == OP_ASL_A) ? cur.acc[7] : operand[7];
				nxt.flags.z = (sh_l == 8'h00);
				nxt.flags.n = sh_l[7];
				if (op == OP_ASL_A) begin
					nxt.acc = sh_l;
				end else begin
					wb.value = sh_l;
					wb.wr    = 1'b1;
				end
			end
			OP_LSR_A, OP_LSR_M: begin
				nxt.flags.c = (op == OP_LSR_A) ? cur.acc[0] : operand[0];
				nxt.flags.z = (sh_r == 8'h00);
				nxt.flags.n = 1'b0;
				if (op == OP_LSR_A) begin
					nxt.acc = sh_r;
				end else begin
					wb.value = sh_r;
					wb.wr    = 1'b1;
				end
			end
			OP_INC_M: begin
				wb.value    = inc_v;
				wb.wr       = 1'b1;
				nxt.flags.z = (inc_v == 8'h00);
				nxt.flags.n = inc_v[7];
			end
			OP_DEC_M: begin
				wb.value    = dec_v;
				wb.wr       = 1'b1;
				nxt.flags.z = (dec_v == 8'h00);
				nxt.flags.n = dec_v[7];
			end
			OP_DEC_R: begin
				if (sel != SEL_NONE) begin
					if (sel == SEL_A) nxt.acc = reg_dec;
					if (sel == SEL_X) nxt.idx_x = reg_dec;
					if (sel == SEL_Y) nxt.idx_y = reg_dec;
					nxt.flags.z = (reg_dec == 8'h00);
					nxt.flags.n = reg_dec[7];
				end
			end
			OP_CMP: begin
				if (sel != SEL_NONE) begin
					nxt.flags.c = ~diff[8];
					nxt.flags.z = (reg_val == operand);
					nxt.flags.n = diff[7];
				end
			end
			OP_BIT: begin
				nxt.flags.z = ((cur.acc & operand) == 8'h00);
				nxt.flags.v = operand[6];
				nxt.flags.n = operand[7];
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule

// ===== src/cpu8_alu_flags_unit.sv =====
// ----------------------------------------------------------------------------
// cpu8_alu_flags_unit - 8-bit binary ALU with A/X/Y and C/Z/V/N flags
// Two-stage valid/ready pipe: input register, ALU, result register.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one operation (code, register select, operand byte,
//   address); res returns the memory write-back byte and strobe, the
//   echoed address, the accumulator and the four flags after that op.
//   A transfer happens on a rising clk edge with valid and ready high.
// Path: a result passes through two register stages, input then result,
//   before it is offered on res after the cmd transfer.
// Throughput: one op per cycle unless res stalls. Register and flag state is
//   updated as an op moves from the input register into the result
//   register, so the next op in the input register always sees it.
// Reset (arst_n low): A, X, Y and all flags clear, both stages empty.
// Receiver stall: the result register holds; the input register keeps
//   filling, so cmd.ready drops only when both stages hold an op.
// ----------------------------------------------------------------------------
module cpu8_alu_flags_unit
	import cpu8alu_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	cpu8alu_cmd_if.sink       cmd,
	cpu8alu_res_if.source     res
);

	// input stage
	logic        vld_s1;
	op_t         op_s1;
	sel_t        sel_s1;
	logic [7:0]  operand_s1;
	logic [15:0] addr_s1;

	// result stage
	logic        vld_s2;
	wb_t         wb_s2;
	logic [15:0] addr_s2;

	// architectural registers and flags
	arch_t       arch_q;
	arch_t       arch_nxt;
	wb_t         wb_nxt;

	logic        adv_s2;
	logic        cmd_xfer;

	// result register can take a new op when empty or being drained
	assign adv_s2    = !vld_s2 || res.ready;
	assign cmd.ready = !vld_s1 || adv_s2;
	assign cmd_xfer  = cmd.valid && cmd.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (cmd_xfer) begin
			vld_s1 <= 1'b1;
		end else if (adv_s2) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_xfer) begin
			op_s1      <= op_t'(cmd.operation);
			sel_s1     <= sel_t'(cmd.reg_select);
			operand_s1 <= cmd.operand;
			addr_s1    <= cmd.address;
		end
	end

	cpu8alu_exec u_exec (
		.cur     (arch_q),
		.op      (op_s1),
		.sel     (sel_s1),
		.operand (operand_s1),
		.nxt     (arch_nxt),
		.wb      (wb_nxt)
	);

	// state commits exactly when the op leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arch_q <= '0;
			vld_s2 <= 1'b0;
		end else if (adv_s2) begin
			vld_s2 <= vld_s1;
			if (vld_s1) begin
				arch_q <= arch_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && vld_s1) begin
			wb_s2   <= wb_nxt;
			addr_s2 <= addr_s1;
		end
	end

	// accumulator and flags in the result register are the committed state
	assign res.valid           = vld_s2;
	assign res.result_value    = wb_s2.value;
	assign res.mem_write       = wb_s2.wr;
	assign res.write_address   = addr_s2;
	assign res.accumulator_out = arch_q.acc;
	assign res.carry           = arch_q.flags.c;
	assign res.zero            = arch_q.flags.z;
	assign res.overflow        = arch_q.flags.v;
	assign res.negative        = arch_q.flags.n;

endmodule

// ===== src/cpu8alu_checker.sv =====
// ----------------------------------------------------------------------------
// cpu8alu_checker - port-level assertions for the ALU flags unit
// Bound to the top level; observes the cmd and res channels only.
// ----------------------------------------------------------------------------
module cpu8alu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cmd_ready,
	input logic        res_valid,
	input logic        res_ready,
	input logic        res_mem_write,
	input logic [7:0]  res_result_value,
	input logic [15:0] res_write_address
);

	// a held result stays offered
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	a_addr_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_write_address))
		else $error("write address changed while stalled");

	// empty result stage never back-pressures the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> cmd_ready)
		else $error("cmd stalled with empty output");

	a_no_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_mem_write |-> res_result_value == 8'h00)
		else $error("nonzero result byte without write strobe");

endmodule

bind cpu8_alu_flags_unit cpu8alu_checker u_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.cmd_ready         (cmd.ready),
	.res_valid         (res.valid),
	.res_ready         (res.ready),
	.res_mem_write     (res.mem_write),
	.res_result_value  (res.result_value),
	.res_write_address (res.write_address)
);
